### rtl/tlca_pkg.sv
package tlca_pkg;

   localparam int NODE_W  = 10;
   localparam int LVL_W   = 5;
   localparam int ENTRY_W = NODE_W + 1;

   // jump entry: {none, node}; "none" is always stored as all ones
   localparam logic [ENTRY_W-1:0] NONE_ENTRY = '1;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [3:0] {
      OP_NOP         = 4'd0,
      OP_CAPTURE     = 4'd1,
      OP_LD_NONE_WR  = 4'd2,
      OP_LD_DEPTH_RD = 4'd3,
      OP_LD_LINK     = 4'd4,
      OP_HOP_RD_U    = 4'd5,
      OP_LD_HOP_WR   = 4'd6,
      OP_RD_DA       = 4'd7,
      OP_RD_DB       = 4'd8,
      OP_ORDER       = 4'd9,
      OP_HOP_WR_U    = 4'd10,
      OP_DSC_RD_V    = 4'd11,
      OP_DSC_UPD     = 4'd12,
      OP_SET_NONE    = 4'd13,
      OP_RESPOND     = 4'd14,
      OP_SHIFT       = 4'd15
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [LVL_W-1:0] lvl;
   } cmd_type;

   typedef struct packed {
      logic query;
      logic first_ok;
      logic second_ok;
      logic root;
      logic diff_top;
      logic u_none;
      logic u_eq_v;
      logic rsp_free;
   } status_type;

   typedef struct packed {
      logic              func;
      logic [NODE_W-1:0] first_node;
      logic [NODE_W-1:0] second_node;
      logic              is_root;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic              found;
   } rsp_type;

endpackage

### rtl/tlca_dpath.sv
module tlca_dpath
   import tlca_pkg::*;
#(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int NW    = (NODES > 2) ? $clog2(NODES) : 1;
   localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int XW    = (NW > LEVELS) ? NW : LEVELS;
   localparam int JAW   = NW + LW;
   localparam int JSIZE = 1 << JAW;
   localparam logic [NW-1:0] DEPTH_MAX = NW'(NODES - 1);

   logic [ENTRY_W-1:0] jump_mem [0:JSIZE-1];
   logic [NW-1:0]      depth_mem [0:NODES-1];

   req_type            req_ff, req_in;
   logic [ENTRY_W-1:0] u_ff, u_in;
   logic [ENTRY_W-1:0] v_ff, v_in;
   logic [ENTRY_W-1:0] pu_ff, pu_in;
   logic [NW-1:0]      du_ff, du_in;
   logic [LEVELS-1:0]  diff_ff, diff_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [ENTRY_W-1:0] jrd_ff;
   logic               rd_none_ff;
   logic [NW-1:0]      drd_ff;

   logic [ENTRY_W-1:0] hop;
   logic [ENTRY_W-1:0] a_entry, b_entry;
   logic [NW-1:0]      a_addr, b_addr;
   logic [LW-1:0]      lvl;
   logic [NW-1:0]      d_inc;
   logic [XW-1:0]      up_diff, dn_diff;

   logic               jrd_en;
   logic [ENTRY_W-1:0] jrd_node;
   logic [JAW-1:0]     jrd_addr;
   logic               jwr_en;
   logic [JAW-1:0]     jwr_addr;
   logic [ENTRY_W-1:0] jwr_data;
   logic               drd_en;
   logic [NW-1:0]      drd_addr;
   logic               dwr_en;
   logic [NW-1:0]      dwr_data;

   always_comb begin
      hop      = rd_none_ff ? NONE_ENTRY : jrd_ff;
      a_entry  = {1'b0, req_ff.first_node};
      b_entry  = {1'b0, req_ff.second_node};
      a_addr   = NW'(req_ff.first_node);
      b_addr   = NW'(req_ff.second_node);
      lvl      = cmd.lvl[LW-1:0];
      d_inc    = (drd_ff >= DEPTH_MAX) ? DEPTH_MAX : NW'(drd_ff + 1'b1);
      up_diff  = XW'(drd_ff) - XW'(du_ff);
      dn_diff  = XW'(du_ff) - XW'(drd_ff);

      req_in       = req_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      pu_in        = pu_ff;
      du_in        = du_ff;
      diff_in      = diff_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      jrd_en   = 1'b0;
      jrd_node = u_ff;
      jwr_en   = 1'b0;
      jwr_data = NONE_ENTRY;
      drd_en   = 1'b0;
      drd_addr = b_addr;
      dwr_en   = 1'b0;
      dwr_data = '0;

      case (cmd.op)
         OP_CAPTURE: begin
            req_in = req_data;
         end
         OP_LD_NONE_WR: begin
            jwr_en   = 1'b1;
            jwr_data = NONE_ENTRY;
            dwr_en   = 1'b1;
            dwr_data = '0;
         end
         OP_LD_DEPTH_RD: begin
            drd_en   = 1'b1;
            drd_addr = b_addr;
         end
         OP_LD_LINK: begin
            jwr_en   = 1'b1;
            jwr_data = b_entry;
            dwr_en   = 1'b1;
            dwr_data = d_inc;
            u_in     = b_entry;
         end
         OP_HOP_RD_U: begin
            jrd_en   = 1'b1;
            jrd_node = u_ff;
         end
         OP_LD_HOP_WR: begin
            jwr_en   = 1'b1;
            jwr_data = hop;
            u_in     = hop;
         end
         OP_RD_DA: begin
            drd_en   = 1'b1;
            drd_addr = a_addr;
         end
         OP_RD_DB: begin
            drd_en   = 1'b1;
            drd_addr = b_addr;
            du_in    = drd_ff;
         end
         OP_ORDER: begin
            if (du_ff < drd_ff) begin
               u_in    = b_entry;
               v_in    = a_entry;
               diff_in = up_diff[LEVELS-1:0];
            end else begin
               u_in    = a_entry;
               v_in    = b_entry;
               diff_in = dn_diff[LEVELS-1:0];
            end
         end
         OP_HOP_WR_U: begin
            u_in    = hop;
            diff_in = diff_ff << 1;
         end
         OP_SHIFT: begin
            diff_in = diff_ff << 1;
         end
         OP_DSC_RD_V: begin
            jrd_en   = 1'b1;
            jrd_node = v_ff;
            pu_in    = hop;
         end
         OP_DSC_UPD: begin
            if (pu_ff != hop) begin
               u_in = pu_ff;
               v_in = hop;
            end
         end
         OP_SET_NONE: begin
            u_in = NONE_ENTRY;
         end
         OP_RESPOND: begin
            rsp_valid_in    = 1'b1;
            rsp_in.found    = !u_ff[NODE_W];
            rsp_in.ancestor = u_ff[NODE_W] ? '0 : u_ff[NODE_W-1:0];
         end
         default: begin
         end
      endcase

      jrd_addr = {NW'(jrd_node[NODE_W-1:0]), lvl};
      jwr_addr = {a_addr, lvl};
   end

   always_ff @(posedge clock) begin
      if (jwr_en) begin
         jump_mem[jwr_addr] <= jwr_data;
      end
      if (jrd_en) begin
         jrd_ff     <= jump_mem[jrd_addr];
         rd_none_ff <= jrd_node[NODE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (dwr_en) begin
         depth_mem[a_addr] <= dwr_data;
      end
      if (drd_en) begin
         drd_ff <= depth_mem[drd_addr];
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      pu_ff   <= pu_in;
      du_ff   <= du_in;
      diff_ff <= diff_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      status.query     = (req_ff.func == FUNC_QUERY);
      status.first_ok  = (32'(req_ff.first_node) < 32'(NODES));
      status.second_ok = (32'(req_ff.second_node) < 32'(NODES));
      status.root      = req_ff.is_root;
      status.diff_top  = diff_ff[LEVELS-1];
      status.u_none    = u_ff[NODE_W];
      status.u_eq_v    = (u_ff == v_ff);
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_rsp_only_from_respond: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == OP_RESPOND))
      else $error("result beat appeared without a respond command");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESPOND) |-> !(rsp_valid_ff && rsp_stall))
      else $error("respond command while a stalled beat is held");

   a_none_canonical: assert property (@(posedge clock) disable iff (reset)
      jwr_en |-> (!jwr_data[NODE_W] || (jwr_data == NONE_ENTRY)))
      else $error("jump entry written with a non-canonical none code");
`endif

endmodule

### rtl/tlca_ctrl.sv
module tlca_ctrl
   import tlca_pkg::*;
#(
   parameter int LEVELS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

   typedef enum logic [16:0] {
      ST_IDLE      = 17'h00001,
      ST_DECODE    = 17'h00002,
      ST_LD_ROOT   = 17'h00004,
      ST_LD_LINK   = 17'h00008,
      ST_LD_HOP_RD = 17'h00010,
      ST_LD_HOP_WR = 17'h00020,
      ST_Q_RD_B    = 17'h00040,
      ST_Q_ORDER   = 17'h00080,
      ST_LIFT_RD   = 17'h00100,
      ST_LIFT_WR   = 17'h00200,
      ST_CHECK     = 17'h00400,
      ST_DSC_RD_U  = 17'h00800,
      ST_DSC_RD_V  = 17'h01000,
      ST_DSC_UPD   = 17'h02000,
      ST_FIN_RD    = 17'h04000,
      ST_FIN_WR    = 17'h08000,
      ST_RESPOND   = 17'h10000
   } state_type;

   state_type     state_ff, state_in;
   logic [LW-1:0] lvl_ff, lvl_in;

   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      cmd.op    = OP_NOP;
      cmd.lvl   = LVL_W'(lvl_ff);
      req_stall = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            lvl_in = '0;
            if (!status.query) begin
               if (!status.first_ok) begin
                  state_in = ST_IDLE;
               end else if (status.root || !status.second_ok) begin
                  state_in = ST_LD_ROOT;
               end else begin
                  cmd.op   = OP_LD_DEPTH_RD;
                  state_in = ST_LD_LINK;
               end
            end else if (status.first_ok && status.second_ok) begin
               cmd.op   = OP_RD_DA;
               state_in = ST_Q_RD_B;
            end else begin
               cmd.op   = OP_SET_NONE;
               state_in = ST_RESPOND;
            end
         end
         ST_LD_ROOT: begin
            cmd.op = OP_LD_NONE_WR;
            if (lvl_ff == LAST_LVL) begin
               state_in = ST_IDLE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_LD_LINK: begin
            cmd.op = OP_LD_LINK;
            if (lvl_ff == LAST_LVL) begin
               state_in = ST_IDLE;
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_LD_HOP_RD;
            end
         end
         ST_LD_HOP_RD: begin
            cmd.op   = OP_HOP_RD_U;
            cmd.lvl  = LVL_W'(lvl_ff - 1'b1);
            state_in = ST_LD_HOP_WR;
         end
         ST_LD_HOP_WR: begin
            cmd.op = OP_LD_HOP_WR;
            if (lvl_ff == LAST_LVL) begin
               state_in = ST_IDLE;
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_LD_HOP_RD;
            end
         end
         ST_Q_RD_B: begin
            cmd.op   = OP_RD_DB;
            state_in = ST_Q_ORDER;
         end
         ST_Q_ORDER: begin
            cmd.op   = OP_ORDER;
            lvl_in   = LAST_LVL;
            state_in = ST_LIFT_RD;
         end
         ST_LIFT_RD: begin
            if (status.diff_top && !status.u_none) begin
               cmd.op   = OP_HOP_RD_U;
               state_in = ST_LIFT_WR;
            end else begin
               cmd.op = OP_SHIFT;
               if (lvl_ff == '0) begin
                  state_in = ST_CHECK;
               end else begin
                  lvl_in = lvl_ff - 1'b1;
               end
            end
         end
         ST_LIFT_WR: begin
            cmd.op = OP_HOP_WR_U;
            if (lvl_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               state_in = ST_LIFT_RD;
            end
         end
         ST_CHECK: begin
            if (status.u_none || status.u_eq_v) begin
               state_in = ST_RESPOND;
            end else begin
               lvl_in   = LAST_LVL;
               state_in = ST_DSC_RD_U;
            end
         end
         ST_DSC_RD_U: begin
            cmd.op   = OP_HOP_RD_U;
            state_in = ST_DSC_RD_V;
         end
         ST_DSC_RD_V: begin
            cmd.op   = OP_DSC_RD_V;
            state_in = ST_DSC_UPD;
         end
         ST_DSC_UPD: begin
            cmd.op = OP_DSC_UPD;
            if (lvl_ff == '0) begin
               state_in = ST_FIN_RD;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               state_in = ST_DSC_RD_U;
            end
         end
         ST_FIN_RD: begin
            cmd.op   = OP_HOP_RD_U;
            state_in = ST_FIN_WR;
         end
         ST_FIN_WR: begin
            cmd.op   = OP_HOP_WR_U;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (status.rsp_free) begin
               cmd.op   = OP_RESPOND;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted beat not followed by decode");

   a_idle_from_end: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> $past(state_ff == ST_RESPOND || state_ff == ST_LD_ROOT ||
                                 state_ff == ST_LD_HOP_WR || state_ff == ST_LD_LINK ||
                                 state_ff == ST_DECODE))
      else $error("returned to idle from a mid-item state");
`endif

endmodule

### rtl/tree_lca_binary_lifting_core.sv
// Lowest-common-ancestor engine with binary lifting, one item at a time. A load beat
// (func 0) stores a node under its parent, or as a root when is_root is set or the parent
// is out of range; parents must be loaded before children. It writes one jump-table
// entry per level, after a table read at each level above 0 (none for a root), and
// gives no result. A query beat (func 1) makes two depth reads, a lift pass of up to
// LEVELS table reads, a descent of two reads per level and a final parent read, the
// table reads all through the single read port of the jump table; it returns one
// beat with the ancestor, or found 0 when the nodes lie in different trees or a node is
// out of range. Nodes that were never loaded must not be queried. req_stall is high
// while an item is in progress; a finished result waits in an output register, and a
// query holds its last cycle for as long as the previous result is still stalled.
module tree_lca_binary_lifting_core
   import tlca_pkg::*;
#(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   tlca_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tlca_dpath #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
